FILE: rtl/m3inv_pkg.sv
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared types, constants and the cofactor operand table for the 3x3
// adjugate inverse block.
// ----------------------------------------------------------------------------
package m3inv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ELEM_W    = 32;
    localparam int PROD_W    = 66;                 // 33 x 33 signed product
    localparam int ADJ_W     = 65;                 // exact cofactor
    localparam int DET_W     = 98;                 // exact determinant
    localparam int QBITS     = 33;                 // quotient bits after overflow check
    localparam int CW        = DET_W + QBITS;      // divider compare width
    localparam int NUM_SHIFT = 2 * FRAC_BITS;

    localparam logic [4:0] COF_STEPS  = 5'd18;
    localparam logic [4:0] LAST_STEP  = 5'd23;
    localparam logic [3:0] LAST_ELEM  = 4'd8;
    localparam logic [5:0] LAST_DIV   = 6'(QBITS - 1);

    typedef struct packed {
        logic       load;
        logic       rd;
        logic       mul;
        logic       acc;
        logic       ard;
        logic       init;
        logic       dstep;
        logic       res;
        logic [4:0] step;
        logic [3:0] idx;
    } m3inv_cmd_t;

    // Element addresses {a, b} of each cofactor product; entry k*2 is the
    // minuend term, k*2+1 the subtrahend term of adjugate entry k.
    function automatic logic [7:0] cof_pair(input logic [4:0] s);
        logic [7:0] r;
        case (s)
            5'd0:    r = {4'd4, 4'd8};
            5'd1:    r = {4'd7, 4'd5};
            5'd2:    r = {4'd7, 4'd2};
            5'd3:    r = {4'd1, 4'd8};
            5'd4:    r = {4'd1, 4'd5};
            5'd5:    r = {4'd4, 4'd2};
            5'd6:    r = {4'd6, 4'd5};
            5'd7:    r = {4'd3, 4'd8};
            5'd8:    r = {4'd0, 4'd8};
            5'd9:    r = {4'd6, 4'd2};
            5'd10:   r = {4'd3, 4'd2};
            5'd11:   r = {4'd0, 4'd5};
            5'd12:   r = {4'd3, 4'd7};
            5'd13:   r = {4'd6, 4'd4};
            5'd14:   r = {4'd6, 4'd1};
            5'd15:   r = {4'd0, 4'd7};
            5'd16:   r = {4'd0, 4'd4};
            5'd17:   r = {4'd3, 4'd1};
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/m3inv_ctrl.sv
// ----------------------------------------------------------------------------
// m3inv_ctrl
// Sequencer: loads elements, steps the shared multiplier through cofactor
// and determinant products, then runs the divider for each nonsingular result.
// ----------------------------------------------------------------------------
module m3inv_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_last,
    input  logic                  det_zero,
    output m3inv_pkg::m3inv_cmd_t cmd
);
    import m3inv_pkg::*;

    typedef enum logic [8:0] {
        S_LOAD = 9'b000000001,
        S_RD   = 9'b000000010,
        S_MUL  = 9'b000000100,
        S_ACC  = 9'b000001000,
        S_ARD  = 9'b000010000,
        S_INIT = 9'b000100000,
        S_DIV  = 9'b001000000,
        S_RES  = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] idx_reg, idx_next;
    logic [4:0] step_reg, step_next;
    logic [5:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            idx_reg   <= '0;
            step_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = (state_reg == S_OUT);
    assign out_last  = (idx_reg == LAST_ELEM);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        cmd.idx    = idx_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (idx_reg == LAST_ELEM)
                    begin
                        idx_next   = '0;
                        step_next  = '0;
                        state_next = S_RD;
                    end
                    else
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    step_next  = '0;
                    state_next = S_ARD;
                end
                else
                begin
                    step_next  = step_reg + 5'd1;
                    state_next = S_RD;
                end
            end
            S_ARD:
            begin
                cmd.ard    = 1'b1;
                state_next = S_INIT;
            end
            S_INIT:
            begin
                // singular matrix: skip the divider
                if (det_zero)
                begin
                    state_next = S_RES;
                end
                else
                begin
                    cmd.init   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.dstep = 1'b1;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == LAST_DIV)
                begin
                    state_next = S_RES;
                end
            end
            S_RES:
            begin
                cmd.res    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (idx_reg == LAST_ELEM)
                    begin
                        idx_next   = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 4'd1;
                        state_next = S_ARD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

FILE: rtl/m3inv_dp.sv
// ----------------------------------------------------------------------------
// m3inv_dp
// Datapath: element memory, shared signed multiplier, cofactor and
// determinant accumulation, restoring divider and result register.
// ----------------------------------------------------------------------------
module m3inv_dp (
    input  logic                  clk,
    input  m3inv_pkg::m3inv_cmd_t cmd,
    input  logic [31:0]           element_value,
    output logic                  det_zero,
    output logic [31:0]           inverse_value,
    output logic                  singular,
    output logic                  saturated
);
    import m3inv_pkg::*;

    logic [ELEM_W-1:0] mem [9];
    logic [ADJ_W-1:0]  adj_mem [9];

    logic [ELEM_W-1:0] rda_reg, rdb_reg;
    logic [ADJ_W-1:0]  adj_rd_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [ADJ_W-1:0]  acc_reg;
    logic [DET_W-1:0]  det_reg;
    logic [CW-1:0]     rem_reg, ds_reg;
    logic [QBITS-1:0]  q_reg;
    logic              neg_reg, ovf_reg;
    logic [31:0]       val_reg;
    logic              sing_reg, sat_reg;

    logic              is_cof;
    logic [4:0]        dstep;
    logic [1:0]        col;
    logic [7:0]        pair;
    logic [3:0]        addr_a, addr_b, addr_adj;
    logic [32:0]       opa, opb;
    logic [DET_W-1:0]  prod_ext;
    logic [DET_W-1:0]  term;
    logic [DET_W-1:0]  det_mag;
    logic [ADJ_W-1:0]  adj_mag;
    logic [CW-1:0]     rem_init, ds_full;
    logic              ge;
    logic [QBITS-1:0]  lim, mag;
    logic              over;

    assign is_cof   = (cmd.step < COF_STEPS);
    assign dstep    = cmd.step - COF_STEPS;
    assign col      = dstep[2:1];
    assign pair     = cof_pair(cmd.step);
    assign addr_a   = is_cof ? pair[7:4] : {2'b00, col};
    assign addr_b   = pair[3:0];
    assign addr_adj = cmd.ard ? cmd.idx : 4'({2'b00, col} * 4'd3);

    assign opa = {rda_reg[ELEM_W-1], rda_reg};
    assign opb = is_cof ? {rdb_reg[ELEM_W-1], rdb_reg}
               : (cmd.step[0] ? adj_rd_reg[ADJ_W-1:32] : {1'b0, adj_rd_reg[31:0]});

    // high half of the cofactor carries weight 2^32
    assign prod_ext = {{(DET_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign term     = cmd.step[0] ? (prod_ext << 32) : prod_ext;

    assign det_zero = (det_reg == '0);
    assign det_mag  = det_reg[DET_W-1] ? (~det_reg + 1'b1) : det_reg;
    assign adj_mag  = adj_rd_reg[ADJ_W-1] ? (~adj_rd_reg + 1'b1) : adj_rd_reg;
    assign rem_init = CW'(adj_mag) << NUM_SHIFT;
    assign ds_full  = CW'(det_mag) << QBITS;
    assign ge       = (rem_reg >= ds_reg);

    assign lim  = neg_reg ? 33'h080000000 : 33'h07FFFFFFF;
    assign over = ovf_reg | (q_reg > lim);
    assign mag  = over ? lim : q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mem[cmd.idx] <= element_value;
        end
        if (cmd.rd)
        begin
            rda_reg <= mem[addr_a];
            rdb_reg <= mem[addr_b];
        end
        if (cmd.rd || cmd.ard)
        begin
            adj_rd_reg <= adj_mem[addr_adj];
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'($signed(opa) * $signed(opb));
        end
        if (cmd.acc)
        begin
            if (is_cof)
            begin
                if (!cmd.step[0])
                begin
                    acc_reg <= prod_reg[ADJ_W-1:0];
                end
                else
                begin
                    adj_mem[cmd.step[4:1]] <= acc_reg - prod_reg[ADJ_W-1:0];
                end
            end
            else
            begin
                det_reg <= ((cmd.step == COF_STEPS) ? '0 : det_reg) + term;
            end
        end
        if (cmd.init)
        begin
            neg_reg <= adj_rd_reg[ADJ_W-1] ^ det_reg[DET_W-1];
            ovf_reg <= (rem_init >= ds_full);
            rem_reg <= rem_init;
            ds_reg  <= ds_full >> 1;
            q_reg   <= '0;
        end
        if (cmd.dstep)
        begin
            rem_reg <= ge ? (rem_reg - ds_reg) : rem_reg;
            q_reg   <= {q_reg[QBITS-2:0], ge};
            ds_reg  <= ds_reg >> 1;
        end
        if (cmd.res)
        begin
            if (det_zero)
            begin
                val_reg  <= '0;
                sing_reg <= 1'b1;
                sat_reg  <= 1'b0;
            end
            else
            begin
                val_reg  <= neg_reg ? (32'd0 - mag[31:0]) : mag[31:0];
                sing_reg <= 1'b0;
                sat_reg  <= over;
            end
        end
    end

    assign inverse_value = val_reg;
    assign singular      = sing_reg;
    assign saturated     = sat_reg;

endmodule

FILE: rtl/matrix3_inverse_top.sv
// ----------------------------------------------------------------------------
// matrix3_inverse_top
// 3x3 Q16.16 matrix inverse by the adjugate method.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: nine transfers carry the matrix elements m[0][0] .. m[2][2]
//   in row order on s_tdata. s_tready is high only while loading.
//   Master stream: nine transfers carry the inverse elements in the same
//   order; m_tuser flags singular and saturated, m_tlast marks the ninth.
//   After the ninth input the shared 33x33 multiplier runs 24 products,
//   each through read, multiply and accumulate states, building the
//   cofactors and the exact determinant. Each result then passes through
//   the 33-step one-bit-per-cycle restoring divider, which a singular
//   matrix skips.
//   A stalled m_tready holds the current result and halts the sequencer;
//   no input is taken until all nine results have transferred.
//   Reset returns to loading with the element count at zero.
// ----------------------------------------------------------------------------
module matrix3_inverse_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] element_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] inverse_value
    output logic [1:0]  m_tuser,   // [0] singular, [1] saturated
    output logic        m_tlast
);
    import m3inv_pkg::*;

    m3inv_cmd_t cmd;
    logic       det_zero;
    logic       singular, saturated;

    m3inv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_last  (m_tlast),
        .det_zero  (det_zero),
        .cmd       (cmd)
    );

    m3inv_dp u_dp (
        .clk           (clk),
        .cmd           (cmd),
        .element_value (s_tdata),
        .det_zero      (det_zero),
        .inverse_value (m_tdata),
        .singular      (singular),
        .saturated     (saturated)
    );

    assign m_tuser = {saturated, singular};

endmodule
